/* rtl/pst_pkg.sv */
package pst_pkg;

    localparam int DEFAULT_CAPACITY = 64;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_CHANGE = 2'd2;
    localparam logic [1:0] KIND_READ   = 2'd3;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_FULL        = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND   = 3'd2;
    localparam logic [2:0] ST_ZERO_HANDLE = 3'd3;
    localparam logic [2:0] ST_RANGE       = 3'd4;

    typedef struct packed {
        logic [1:0]         kind;
        logic [31:0]        handle;
        logic signed [31:0] priority_req;
        logic [5:0]         index;
    } pst_in_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [31:0]        entry_handle;
        logic signed [31:0] entry_priority;
        logic [6:0]         entry_count;
    } pst_out_t;

    typedef struct packed {
        logic               valid;
        logic [31:0]        handle;
        logic signed [31:0] prio;
    } pst_entry_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2
    } pst_cell_cmd_t;

    typedef struct packed {
        pst_cell_cmd_t      cmd;
        logic               load;
        logic [31:0]        key_handle;
        logic signed [31:0] key_priority;
    } pst_cell_ctrl_t;

endpackage

/* rtl/priority_sorted_table.sv */
// Sorted table of (handle, signed priority) entries, highest priority first.
// Requests arrive on the s_ channel (s_valid, s_ready, s_data) and each gives
// exactly one result on the m_ channel (m_valid, m_ready, m_data) carrying a
// status, the entry read (zero unless a successful read) and the count.
// Entries sit in a row of cells; every cell compares itself with the request
// key when a transfer is accepted, and at the end of the following cycle a
// successful insert or remove shifts the cells from the insert point or the
// removed entry onwards by one place. Insert, remove and read load their result
// into m_data, or into the hold register if the receiver stalls. A priority
// change runs a remove pass, a fresh compare against the shortened row and an
// insert pass. The row shifts at the same edge that stores the result; s_ready
// is high only when idle, so no request is accepted while one is in progress.
// If the receiver stalls, a finished result waits in the output register
// while the next request is accepted and worked on; that request's result is
// then held inside until the output register is free.
// Reset empties the table at once: the valid bit of every cell is cleared.
module priority_sorted_table import pst_pkg::*; #(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  pst_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output pst_out_t m_data
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CW > 6) ? CW : 6;
    localparam int XW = CW + 7;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_APPLY = 4'b0010,
        S_LOOK  = 4'b0100,
        S_WAIT  = 4'b1000
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic               second_reg;
    logic               second_next;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [1:0]         kind_reg;
    logic [31:0]        handle_reg;
    logic signed [31:0] prio_reg;
    logic [5:0]         index_reg;
    logic               m_valid_reg;
    logic               m_valid_next;
    pst_out_t           m_data_reg;
    pst_out_t           m_data_next;
    pst_out_t           hold_reg;
    pst_out_t           hold_next;

    pst_cell_ctrl_t     ctrl;
    pst_cell_cmd_t      cmd;
    pst_entry_t         cell_entry [CAPACITY];
    logic [CAPACITY-1:0] ge_vec;
    logic [CAPACITY:0]  prior_chain;
    logic [CAPACITY-1:0] valid_vec;
    pst_entry_t         rd_entry;
    pst_out_t           res;
    logic               finish;
    logic               out_free;
    logic               s_fire;
    logic               found;
    logic               in_range;
    logic [XW-1:0]      count_x;

    assign s_ready  = (state_reg == S_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign found    = prior_chain[CAPACITY];
    assign in_range = IW'(index_reg) < IW'(count_reg);

    assign ctrl.cmd          = cmd;
    assign ctrl.load         = s_fire || (state_reg == S_LOOK);
    assign ctrl.key_handle   = (state_reg == S_IDLE) ? s_data.handle : handle_reg;
    assign ctrl.key_priority = (state_reg == S_IDLE) ? s_data.priority_req : prio_reg;

    assign prior_chain[0] = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        pst_entry_t left_e;
        pst_entry_t right_e;
        logic       left_g;

        if (i == 0) begin : g_first
            assign left_e = '0;
            assign left_g = 1'b1;
        end else begin : g_mid
            assign left_e = cell_entry[i-1];
            assign left_g = ge_vec[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_e = '0;
        end else begin : g_inner
            assign right_e = cell_entry[i+1];
        end

        pst_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .left_entry  (left_e),
            .left_ge     (left_g),
            .right_entry (right_e),
            .prior_in    (prior_chain[i]),
            .entry       (cell_entry[i]),
            .ge          (ge_vec[i]),
            .prior_out   (prior_chain[i+1])
        );

        assign valid_vec[i] = cell_entry[i].valid;
    end

    always_comb begin
        rd_entry = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (IW'(i) == IW'(index_reg)) begin
                rd_entry = rd_entry | cell_entry[i];
            end
        end
    end

    always_comb begin
        state_next   = state_reg;
        second_next  = second_reg;
        count_next   = count_reg;
        cmd          = CELL_HOLD;
        finish       = 1'b0;
        res          = '0;
        hold_next    = hold_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        unique case (state_reg)
            S_IDLE: begin
                second_next = 1'b0;
                if (s_fire) begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY: begin
                finish = 1'b1;
                unique case (kind_reg)
                    KIND_INSERT: begin
                        if (handle_reg == '0) begin
                            res.status = ST_ZERO_HANDLE;
                        end else if (count_reg >= CW'(CAPACITY)) begin
                            res.status = ST_FULL;
                        end else begin
                            cmd        = CELL_INSERT;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    KIND_REMOVE: begin
                        if (!found) begin
                            res.status = ST_NOT_FOUND;
                        end else begin
                            cmd        = CELL_REMOVE;
                            count_next = count_reg - CW'(1);
                        end
                    end
                    KIND_CHANGE: begin
                        if (second_reg) begin
                            cmd        = CELL_INSERT;
                            count_next = count_reg + CW'(1);
                        end else if (!found) begin
                            res.status = ST_NOT_FOUND;
                        end else begin
                            cmd         = CELL_REMOVE;
                            count_next  = count_reg - CW'(1);
                            finish      = 1'b0;
                            second_next = 1'b1;
                            state_next  = S_LOOK;
                        end
                    end
                    KIND_READ: begin
                        if (in_range) begin
                            res.entry_handle   = rd_entry.handle;
                            res.entry_priority = rd_entry.prio;
                        end else begin
                            res.status = ST_RANGE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_LOOK: begin
                state_next = S_APPLY;
            end
            S_WAIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = hold_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        count_x         = XW'(count_next);
        res.entry_count = count_x[6:0];

        if (finish) begin
            if (out_free) begin
                m_valid_next = 1'b1;
                m_data_next  = res;
                state_next   = S_IDLE;
            end else begin
                hold_next  = res;
                state_next = S_WAIT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            second_reg  <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            second_reg  <= second_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        hold_reg   <= hold_next;
        if (s_fire) begin
            kind_reg   <= s_data.kind;
            handle_reg <= s_data.handle;
            prio_reg   <= s_data.priority_req;
            index_reg  <= s_data.index;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_vec) == int'(count_reg))
        else $error("occupied cells disagree with the entry count");

    assert property (@(posedge aclk) disable iff (!aresetn)
        ((valid_vec + CAPACITY'(1)) & valid_vec) == '0)
        else $error("occupied cells are not a contiguous prefix of the row");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WAIT) |-> m_valid_reg)
        else $error("result held back while the output register is empty");

endmodule

/* rtl/pst_cell.sv */
module pst_cell import pst_pkg::*; (
    input  logic           aclk,
    input  logic           aresetn,
    input  pst_cell_ctrl_t ctrl,
    input  pst_entry_t     left_entry,
    input  logic           left_ge,
    input  pst_entry_t     right_entry,
    input  logic           prior_in,
    output pst_entry_t     entry,
    output logic           ge,
    output logic           prior_out
);

    logic               valid_reg;
    logic               valid_next;
    logic [31:0]        handle_reg;
    logic [31:0]        handle_next;
    logic signed [31:0] prio_reg;
    logic signed [31:0] prio_next;
    logic               ge_reg;
    logic               hit_reg;

    // Flags are taken against the key while the table is still; the shift uses them next.
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            ge_reg  <= valid_reg && !(prio_reg < ctrl.key_priority);
            hit_reg <= valid_reg && (handle_reg == ctrl.key_handle);
        end
    end

    always_comb begin
        valid_next  = valid_reg;
        handle_next = handle_reg;
        prio_next   = prio_reg;
        case (ctrl.cmd)
            CELL_INSERT: begin
                if (!ge_reg) begin
                    if (left_ge) begin
                        valid_next  = 1'b1;
                        handle_next = ctrl.key_handle;
                        prio_next   = ctrl.key_priority;
                    end else begin
                        valid_next  = left_entry.valid;
                        handle_next = left_entry.handle;
                        prio_next   = left_entry.prio;
                    end
                end
            end
            CELL_REMOVE: begin
                if (prior_in || hit_reg) begin
                    valid_next  = right_entry.valid;
                    handle_next = right_entry.handle;
                    prio_next   = right_entry.prio;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        handle_reg <= handle_next;
        prio_reg   <= prio_next;
    end

    assign entry     = '{valid: valid_reg, handle: handle_reg, prio: prio_reg};
    assign ge        = ge_reg;
    assign prior_out = prior_in | hit_reg;

endmodule

/* test/priority_sorted_table_tb.sv */
module priority_sorted_table_tb;
    import pst_pkg::*;

    localparam int CAPACITY     = DEFAULT_CAPACITY;
    localparam int RANDOM_ITEMS = 1530;
    localparam int STALL_LIMIT  = 5000;

    class table_scoreboard;
        logic [31:0]        slot_handle [CAPACITY];
        logic signed [31:0] slot_prio [CAPACITY];
        int                 fill;
        pst_out_t           expected_q [$];
        int                 mismatches;

        function new();
            fill = 0;
            mismatches = 0;
        endfunction

        function int find_handle(logic [31:0] h);
            for (int i = 0; i < fill; i++) begin
                if (slot_handle[i] == h) begin
                    return i;
                end
            end
            return -1;
        endfunction

        // A new entry goes after every entry of greater or equal priority.
        function void place(logic [31:0] h, logic signed [31:0] p);
            int pos;
            pos = 0;
            while (pos < fill && !(slot_prio[pos] < p)) begin
                pos++;
            end
            for (int i = fill; i > pos; i--) begin
                slot_handle[i] = slot_handle[i - 1];
                slot_prio[i]   = slot_prio[i - 1];
            end
            slot_handle[pos] = h;
            slot_prio[pos]   = p;
            fill++;
        endfunction

        function void drop(int pos);
            for (int i = pos; i + 1 < fill; i++) begin
                slot_handle[i] = slot_handle[i + 1];
                slot_prio[i]   = slot_prio[i + 1];
            end
            fill--;
        endfunction

        function void note_request(pst_in_t req);
            pst_out_t res;
            int       pos;
            res = '0;
            res.status = ST_OK;
            case (req.kind)
                KIND_INSERT: begin
                    if (req.handle == 32'd0) begin
                        res.status = ST_ZERO_HANDLE;
                    end else if (fill >= CAPACITY) begin
                        res.status = ST_FULL;
                    end else begin
                        place(req.handle, req.priority_req);
                    end
                end
                KIND_REMOVE, KIND_CHANGE: begin
                    pos = find_handle(req.handle);
                    if (pos < 0) begin
                        res.status = ST_NOT_FOUND;
                    end else begin
                        drop(pos);
                        if (req.kind == KIND_CHANGE) begin
                            place(req.handle, req.priority_req);
                        end
                    end
                end
                default: begin
                    if (int'(req.index) < fill) begin
                        res.entry_handle   = slot_handle[req.index];
                        res.entry_priority = slot_prio[req.index];
                    end else begin
                        res.status = ST_RANGE;
                    end
                end
            endcase
            res.entry_count = 7'(fill);
            expected_q.push_back(res);
        endfunction

        function void report(string what, logic [31:0] want, logic [31:0] got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%s: expected %h, got %h", what, want, got);
            end
        endfunction

        function void check_result(pst_out_t got);
            pst_out_t want;
            if (expected_q.size() == 0) begin
                report("result with no request outstanding, handle", 32'd0, got.entry_handle);
            end else begin
                want = expected_q.pop_front();
                if (got.status !== want.status) begin
                    report("status", 32'(want.status), 32'(got.status));
                end
                if (got.entry_handle !== want.entry_handle) begin
                    report("entry_handle", want.entry_handle, got.entry_handle);
                end
                if (got.entry_priority !== want.entry_priority) begin
                    report("entry_priority", want.entry_priority, got.entry_priority);
                end
                if (got.entry_count !== want.entry_count) begin
                    report("entry_count", 32'(want.entry_count), 32'(got.entry_count));
                end
            end
        endfunction
    endclass

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    pst_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    pst_out_t m_data;
    bit       quiet   = 1'b0;

    table_scoreboard sb = new();

    priority_sorted_table dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_data);
        end
        m_ready <= quiet || ($urandom_range(99) >= 14);
    end

    task automatic send(pst_in_t req);
        if (!quiet) begin
            while ($urandom_range(99) < 14) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        sb.note_request(req);
    endtask

    task automatic send_fields(logic [1:0] kind, logic [31:0] handle,
                               logic [31:0] prio, logic [5:0] index);
        pst_in_t req;
        req.kind         = kind;
        req.handle       = handle;
        req.priority_req = prio;
        req.index        = index;
        send(req);
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (sb.expected_q.size() != 0);
    endtask

    function automatic pst_in_t random_request(bit filling);
        pst_in_t req;
        int      r;
        r = $urandom_range(99);
        if (filling) begin
            req.kind = (r < 60) ? KIND_INSERT : (r < 70) ? KIND_REMOVE :
                       (r < 85) ? KIND_CHANGE : KIND_READ;
        end else begin
            req.kind = (r < 15) ? KIND_INSERT : (r < 65) ? KIND_REMOVE :
                       (r < 80) ? KIND_CHANGE : KIND_READ;
        end
        r = $urandom_range(99);
        if (req.kind == KIND_INSERT) begin
            req.handle = (r < 5) ? 32'd0 : (r < 75) ? 32'($urandom_range(40, 1)) : $urandom;
        end else if (r < 75 && sb.fill > 0) begin
            req.handle = sb.slot_handle[$urandom_range(sb.fill - 1)];
        end else begin
            req.handle = (r < 85) ? 32'd0 : (r < 95) ? 32'($urandom_range(40, 1)) : $urandom;
        end
        r = $urandom_range(99);
        if (r < 50) begin
            req.priority_req = 32'(int'($urandom_range(8)) - 4);
        end else if (r < 60) begin
            req.priority_req = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
        end else begin
            req.priority_req = $urandom;
        end
        r = $urandom_range(99);
        if (r < 80 && sb.fill > 0) begin
            req.index = 6'($urandom_range(sb.fill - 1));
        end else begin
            req.index = 6'($urandom_range(63));
        end
        return req;
    endfunction

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("priority_sorted_table: mismatch");
        $finish;
    end

    initial begin
        bit filling;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        send_fields(KIND_READ,   32'd0,         32'd0,         6'd0);
        send_fields(KIND_REMOVE, 32'd5,         32'd0,         6'd0);
        send_fields(KIND_CHANGE, 32'd5,         32'd9,         6'd0);
        send_fields(KIND_INSERT, 32'd0,         32'd3,         6'd0);
        send_fields(KIND_INSERT, 32'hffff_ffff, 32'h7fff_ffff, 6'd0);
        send_fields(KIND_INSERT, 32'd1,         32'h8000_0000, 6'd0);
        send_fields(KIND_INSERT, 32'd2,         32'd0,         6'd0);
        send_fields(KIND_INSERT, 32'd3,         32'd0,         6'd0);
        send_fields(KIND_INSERT, 32'd2,         32'd0,         6'd0);
        send_fields(KIND_INSERT, 32'haaaa_aaaa, 32'hffff_ffff, 6'd0);
        send_fields(KIND_INSERT, 32'h5555_5555, 32'd1,         6'd0);
        send_fields(KIND_READ,   32'd0,         32'd0,         6'd0);
        send_fields(KIND_READ,   32'd0,         32'd0,         6'd6);
        send_fields(KIND_READ,   32'd0,         32'd0,         6'd7);
        send_fields(KIND_READ,   32'd0,         32'd0,         6'd63);
        send_fields(KIND_CHANGE, 32'd2,         32'd0,         6'd0);
        send_fields(KIND_CHANGE, 32'd1,         32'h7fff_ffff, 6'd0);
        send_fields(KIND_REMOVE, 32'd2,         32'd0,         6'd0);
        send_fields(KIND_REMOVE, 32'd0,         32'd0,         6'd0);
        send_fields(KIND_CHANGE, 32'd0,         32'd4,         6'd0);
        send_fields(KIND_READ,   32'd0,         32'd0,         6'd1);
        send_fields(KIND_READ,   32'd0,         32'd0,         6'd2);
        send_fields(KIND_READ,   32'd0,         32'd0,         6'd3);
        wait_for_results();

        // The table is filled to capacity and drained again several times over.
        filling = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            quiet = (n >= 600 && n < 900);
            if (n == 400 || n == 1100) begin
                wait_for_results();
            end
            if (filling && sb.fill == CAPACITY && $urandom_range(7) == 0) begin
                filling = 1'b0;
            end else if (!filling && sb.fill == 0) begin
                filling = 1'b1;
            end
            send(random_request(filling));
        end
        quiet = 1'b0;
        wait_for_results();
        repeat (16) @(posedge aclk);

        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("priority_sorted_table: match");
        end else begin
            $display("priority_sorted_table: mismatch");
        end
        $finish;
    end
endmodule
